### rtl/core/csvg_pkg.sv
// Shared types, constants and the quarter-wave sine table builder for the
// cylinder strip vertex generator. No dependencies.
package csvg_pkg;

	localparam int SINE_TABLE_SIZE = 1024;
	localparam int MAX_SUBDIVISIONS = 255;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	localparam int SINE_W = 17;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_SIZE + 1);
	localparam int POS_XZ_W = 17;
	localparam int POS_Y_W = 24;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROFILE_RADIUS = 3'd0,
		CFG_RING_SPACING   = 3'd1,
		CFG_COLUMNS        = 3'd2,
		CFG_RINGS          = 3'd3,
		CFG_ANGLE_STEP     = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [15:0] profile_radius;
		logic [15:0] ring_spacing;
		logic [7:0]  columns;
		logic [7:0]  rings;
		logic [15:0] angle_step;
	} cfg_t;

	localparam logic [15:0] RST_PROFILE_RADIUS = 16'd25600;
	localparam logic [15:0] RST_RING_SPACING   = 16'd5120;
	localparam logic [7:0]  RST_COLUMNS        = 8'd40;
	localparam logic [7:0]  RST_RINGS          = 8'd10;
	localparam logic [15:0] RST_ANGLE_STEP     = 16'd1638;

	// one accepted tick, as handed from the front to the back
	typedef struct packed {
		logic [15:0]        phase;
		logic [POS_Y_W-1:0] pos_y;
		logic [1:0]         count;
		logic               mesh_done;
	} cmd_t;

	typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_SIZE];

	function automatic logic [63:0] taylor_next(input logic [63:0] t, input logic [63:0] a);
		return (((t * a) >> 30) * a) >> 30;
	endfunction

	// sin(pi/2 * k/N) in Q16, Taylor series in Q30
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] a;
		logic [63:0] s;
		logic [63:0] t;
		for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
			a = (PI_HALF_Q30 * 64'(k)) / SINE_TABLE_SIZE;
			s = a;
			t = a;
			t = taylor_next(t, a) / 6;   s = s - t;
			t = taylor_next(t, a) / 20;  s = s + t;
			t = taylor_next(t, a) / 42;  s = s - t;
			t = taylor_next(t, a) / 72;  s = s + t;
			t = taylor_next(t, a) / 110; s = s - t;
			t = taylor_next(t, a) / 156; s = s + t;
			t = taylor_next(t, a) / 210; s = s - t;
			t = taylor_next(t, a) / 272; s = s + t;
			t = taylor_next(t, a) / 342; s = s - t;
			rom[k] = SINE_W'((s + 64'd8192) >> 14);
		end
		return rom;
	endfunction

endpackage

### rtl/core/csvg_if.sv
// Valid/ready channel interfaces: tick input and vertex output.
// Depends on csvg_pkg for field widths.
interface tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface vertex_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [csvg_pkg::POS_XZ_W-1:0] pos_x;
	logic [csvg_pkg::POS_Y_W-1:0]         pos_y;
	logic signed [csvg_pkg::POS_XZ_W-1:0] pos_z;
	logic                                 last;
	logic                                 mesh_done;

	modport source (output valid, output pos_x, output pos_y, output pos_z, output last,
		output mesh_done, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, input last,
		input mesh_done, output ready);
endinterface

### rtl/core/cylinder_strip_vertex_generator.sv
// Top level of the cylinder strip vertex generator: configuration registers,
// front end, command queue and back end. Depends on csvg_pkg, csvg_if and the csvg_* modules.
//
//   channel   dir  beat                                   handshake
//   tick      in   restart                                valid/ready
//   vertex    out  pos_x, pos_y, pos_z, last, mesh_done   valid/ready
//   cfg       in   cfg_index, cfg_data                    cfg_we, no back-pressure
//
// The front takes one tick per cycle while the command queue has room.
// Per command the back does the table lookup, the radius scaling, then emits one beat for a
// plain tick, three for a row turn with its two pivot beats, and pops the next on the last.
// Reset restores register defaults and the start of the strip; the sine table is constant.
// A stalled vertex beat holds; ticks keep flowing in until the queue fills.
module cylinder_strip_vertex_generator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [csvg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csvg_pkg::CFG_DATA_W-1:0] cfg_data,
	tick_if.sink                           tick,
	vertex_if.source                       vertex
);
	import csvg_pkg::*;

	cfg_t cfg_q;
	logic q_full, q_empty, q_push, q_pop;
	cmd_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.profile_radius <= RST_PROFILE_RADIUS;
			cfg_q.ring_spacing   <= RST_RING_SPACING;
			cfg_q.columns        <= RST_COLUMNS;
			cfg_q.rings          <= RST_RINGS;
			cfg_q.angle_step     <= RST_ANGLE_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROFILE_RADIUS: cfg_q.profile_radius <= cfg_data;
				CFG_RING_SPACING:   cfg_q.ring_spacing   <= cfg_data;
				CFG_COLUMNS:        cfg_q.columns        <= cfg_data[7:0];
				CFG_RINGS:          cfg_q.rings          <= cfg_data[7:0];
				CFG_ANGLE_STEP:     cfg_q.angle_step     <= cfg_data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	csvg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.tick   (tick),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (push_data)
	);

	csvg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	csvg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.q_pop   (q_pop),
		.vertex  (vertex)
	);

endmodule

### rtl/core/csvg_front.sv
// Front end: accepts ticks, walks the serpentine (column, ring) grid and
// pushes one command per tick. Depends on csvg_pkg, csvg_if.
module csvg_front (
	input  logic            clk,
	input  logic            arst_n,
	input  csvg_pkg::cfg_t  cfg,
	tick_if.sink            tick,
	input  logic            q_full,
	output logic            q_push,
	output csvg_pkg::cmd_t  q_data
);
	import csvg_pkg::*;

	logic [7:0] column_q, ring_q;
	logic       going_right_q, step_a_q, finished_q;

	logic       clr;
	logic [7:0] col, rg, cols;
	logic       gr, sa, fin;
	logic       turn, sa_n, gr_n, fin_n;
	logic [15:0] phase_lo;

	always_comb begin
		clr  = tick.restart | finished_q;
		col  = clr ? 8'd0 : column_q;
		rg   = clr ? 8'd0 : ring_q;
		gr   = clr ? 1'b1 : going_right_q;
		sa   = clr ? 1'b1 : step_a_q;
		fin  = clr ? 1'b0 : finished_q;
		cols = (32'(cfg.columns) > 32'(MAX_SUBDIVISIONS)) ? 8'(MAX_SUBDIVISIONS)
			: cfg.columns;
		turn = !sa && ((gr && col == cols) || (!gr && col == 8'd0));
		sa_n  = sa | turn;
		gr_n  = turn ? !gr : gr;
		fin_n = turn ? (rg == cfg.rings) : fin;
		// phase wraps at a full circle, so only the low 16 product bits matter
		phase_lo = 16'(col) * cfg.angle_step;
	end

	assign tick.ready = !q_full;
	assign q_push     = tick.valid & !q_full;

	always_comb begin
		q_data.phase     = phase_lo;
		q_data.pos_y     = 24'(cfg.ring_spacing) * 24'(rg);
		q_data.count     = turn ? 2'd3 : 2'd1;
		q_data.mesh_done = turn & fin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q      <= '0;
			ring_q        <= '0;
			going_right_q <= 1'b1;
			step_a_q      <= 1'b1;
			finished_q    <= 1'b0;
		end else if (q_push) begin
			going_right_q <= gr_n;
			finished_q    <= fin_n;
			step_a_q      <= !sa_n;
			if (sa_n) begin
				ring_q   <= rg + 8'd1;
				column_q <= col;
			end else begin
				ring_q   <= rg - 8'd1;
				column_q <= gr_n ? col + 8'd1 : col - 8'd1;
			end
		end
	end

endmodule

### rtl/core/csvg_queue.sv
// Small command FIFO between front and back.
// Depends on csvg_pkg.
module csvg_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csvg_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output csvg_pkg::cmd_t  pop_data,
	output logic            empty
);
	import csvg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop && !empty)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/csvg_back.sv
// Back end: sine table lookup, radius scaling and vertex beat emission,
// one to three beats per command. Depends on csvg_pkg, csvg_if.
module csvg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  csvg_pkg::cfg_t  cfg,
	input  logic            q_empty,
	input  csvg_pkg::cmd_t  q_data,
	output logic            q_pop,
	vertex_if.source        vertex
);
	import csvg_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam int PROD_W = 14 + SINE_IDX_W;

	typedef enum logic [3:0] {
		BK_IDLE = 4'b0001,
		BK_LOOK = 4'b0010,
		BK_MUL  = 4'b0100,
		BK_EMIT = 4'b1000
	} back_state_t;

	back_state_t state_q;
	cmd_t        cmd_s1;
	logic [SINE_W-1:0] t_cos_s2, t_sin_s2;
	logic        neg_cos_s2, neg_sin_s2;
	logic [1:0]  rem_q;
	logic signed [POS_XZ_W-1:0] pos_x_q, pos_z_q;
	logic [POS_Y_W-1:0] pos_y_q;
	logic        mesh_done_q;

	logic [15:0] cos_phase;
	logic [SINE_IDX_W-1:0] idx_cos, idx_sin;
	logic        fire, final_beat;
	logic [32:0] prod_x, prod_z;
	logic [SINE_W-1:0] mag_x, mag_z;

	// quadrant fold of a 16-bit phase into a table index
	function automatic logic [SINE_IDX_W-1:0] fold_index(input logic [15:0] p);
		logic [PROD_W-1:0] scaled;
		logic [SINE_IDX_W-1:0] i;
		scaled = PROD_W'(p[13:0]) * PROD_W'(SINE_TABLE_SIZE);
		i = scaled[PROD_W-1:14];
		return p[14] ? SINE_IDX_W'(SINE_TABLE_SIZE) - i : i;
	endfunction

	always_comb begin
		cos_phase = cmd_s1.phase + 16'd16384;
		idx_cos   = fold_index(cos_phase);
		idx_sin   = fold_index(cmd_s1.phase);
		prod_x    = 33'(cfg.profile_radius) * 33'(t_cos_s2) + 33'd32768;
		prod_z    = 33'(cfg.profile_radius) * 33'(t_sin_s2) + 33'd32768;
		mag_x     = prod_x[32:16];
		mag_z     = prod_z[32:16];
	end

	assign fire       = vertex.valid & vertex.ready;
	assign final_beat = rem_q == 2'd1;
	assign q_pop      = !q_empty && (state_q == BK_IDLE || (fire && final_beat));

	assign vertex.valid     = state_q == BK_EMIT;
	assign vertex.pos_x     = pos_x_q;
	assign vertex.pos_y     = pos_y_q;
	assign vertex.pos_z     = pos_z_q;
	assign vertex.last      = final_beat;
	assign vertex.mesh_done = mesh_done_q;

	always_ff @(posedge clk) begin
		if (q_pop)
			cmd_s1 <= q_data;
		if (state_q == BK_LOOK) begin
			t_cos_s2   <= SINE_ROM[idx_cos];
			t_sin_s2   <= SINE_ROM[idx_sin];
			neg_cos_s2 <= cos_phase[15];
			neg_sin_s2 <= cmd_s1.phase[15];
		end
		if (state_q == BK_MUL) begin
			pos_x_q     <= neg_cos_s2 ? -$signed(mag_x) : $signed(mag_x);
			pos_z_q     <= neg_sin_s2 ? -$signed(mag_z) : $signed(mag_z);
			pos_y_q     <= cmd_s1.pos_y;
			mesh_done_q <= cmd_s1.mesh_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rem_q   <= '0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (q_pop)
						state_q <= BK_LOOK;
				end
				BK_LOOK: state_q <= BK_MUL;
				BK_MUL: begin
					rem_q   <= cmd_s1.count;
					state_q <= BK_EMIT;
				end
				BK_EMIT: begin
					if (fire) begin
						rem_q <= rem_q - 2'd1;
						if (final_beat)
							state_q <= q_pop ? BK_LOOK : BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule
